// ----- src/skt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package skt_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 37;
    localparam int PAY_W    = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [PAY_W-1:0] payload_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef struct packed {
        logic     ins_en;
        logic     rem_en;
        key_t     key;
        payload_t payload;
    } skt_cmd_t;

    typedef struct packed {
        key_t     key;
        payload_t payload;
        logic     gt;
        logic     eq;
        logic     valid;
    } skt_link_t;

endpackage
`default_nettype wire

// ----- src/skt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module skt_cell
    import skt_pkg::*;
(
    input  wire logic      clk,
    input  wire skt_cmd_t  cmd,
    input  wire logic      valid,
    input  wire logic      pos_ge,
    input  wire skt_link_t left,
    input  wire skt_link_t right,
    output skt_link_t      link,
    output logic           ins_here,
    output logic           first_hit
);

    key_t     key_reg;
    key_t     key_next;
    payload_t payload_reg;
    payload_t payload_next;
    logic     gt;
    logic     eq;

    assign gt        = valid && (key_reg > cmd.key);
    assign eq        = valid && (key_reg == cmd.key);
    assign ins_here  = left.valid && !left.gt && (gt || !valid);
    assign first_hit = eq && !left.eq;

    assign link.key     = key_reg;
    assign link.payload = payload_reg;
    assign link.gt      = gt;
    assign link.eq      = eq;
    assign link.valid   = valid;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.ins_en)
        begin
            if (left.gt)
            begin
                key_next     = left.key;
                payload_next = left.payload;
            end
            else if (ins_here)
            begin
                key_next     = cmd.key;
                payload_next = cmd.payload;
            end
        end
        else if (cmd.rem_en && pos_ge)
        begin
            key_next     = right.key;
            payload_next = right.payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

endmodule
`default_nettype wire

// ----- src/sorted_key_table.sv -----
// Sorted key table: up to 64 entries kept in ascending key order in a row of
// cells, each cell holding one key and payload and comparing it against the
// request key in parallel. A request is taken when start is high and busy is
// low; insert, search and remove all finish in a compare step (the cells
// compare and shift) followed by an encode step (the hit position is encoded
// and the found payload selected); busy is high during the encode step, so a
// new request cannot be taken until it falls. The result on the result ports
// is flagged by done, high for exactly one cycle and registered from busy;
// the receiver cannot stall it and must take it in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table
    import skt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       mode,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [PAY_W-1:0] payload,
    input  wire logic [POS_W-1:0] position,
    output logic                  done,
    output logic                  success,
    output logic [POS_W-1:0]      result_position,
    output logic [PAY_W-1:0]      found_payload,
    output logic [CNT_W-1:0]      entry_count
);

    logic                 accept;
    logic                 full;
    logic                 pos_ok;
    skt_cmd_t             cmd;
    skt_link_t            links [CAPACITY];
    logic [CAPACITY-1:0]  ins_vec;
    logic [CAPACITY-1:0]  hit_vec;
    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  pos_ge_vec;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CAPACITY-1:0]  hot_reg;
    logic [CAPACITY-1:0]  hot_next;
    logic                 search_reg;
    logic                 ok_reg;
    logic                 ok_next;
    logic                 success_reg;
    logic [POS_W-1:0]     rpos_reg;
    logic [POS_W-1:0]     rpos_next;
    logic [PAY_W-1:0]     fpay_reg;
    logic [PAY_W-1:0]     fpay_next;
    logic [CNT_W-1:0]     cnt_out_reg;

    assign accept = start && !busy_reg;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign pos_ok = ({1'b0, position} < count_reg);

    assign cmd.ins_en  = accept && (mode == OP_INSERT) && !full;
    assign cmd.rem_en  = accept && (mode == OP_REMOVE) && pos_ok;
    assign cmd.key     = key;
    assign cmd.payload = payload;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            skt_link_t left_link;
            skt_link_t right_link;

            assign valid_vec[gi]  = (count_reg > CNT_W'(gi));
            assign pos_ge_vec[gi] = ({1'b0, position} <= CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign left_link = '{key: '0, payload: '0, gt: 1'b0, eq: 1'b0,
                                     valid: 1'b1};
            end
            else
            begin : g_mid
                assign left_link = links[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_link = links[gi];
            end
            else
            begin : g_body
                assign right_link = links[gi+1];
            end

            skt_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .valid     (valid_vec[gi]),
                .pos_ge    (pos_ge_vec[gi]),
                .left      (left_link),
                .right     (right_link),
                .link      (links[gi]),
                .ins_here  (ins_vec[gi]),
                .first_hit (hit_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        hot_next   = '0;
        ok_next    = 1'b0;
        case (mode)
            OP_INSERT:
            begin
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                    hot_next   = ins_vec;
                    ok_next    = 1'b1;
                end
            end
            OP_SEARCH:
            begin
                hot_next = hit_vec;
                ok_next  = |hit_vec;
            end
            OP_REMOVE:
            begin
                if (pos_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rpos_next = '0;
        fpay_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hot_reg[i])
            begin
                rpos_next = rpos_next | POS_W'(i);
                if (search_reg)
                begin
                    fpay_next = fpay_next | links[i].payload;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (accept)
            begin
                count_reg <= count_next;
                busy_reg  <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hot_reg     <= hot_next;
            ok_reg      <= ok_next;
            search_reg  <= (mode == OP_SEARCH);
            cnt_out_reg <= count_next;
        end
        if (busy_reg)
        begin
            success_reg <= ok_reg;
            rpos_reg    <= rpos_next;
            fpay_reg    <= fpay_next;
        end
    end

    assign busy            = busy_reg;
    assign done            = done_reg;
    assign success         = success_reg;
    assign result_position = rpos_reg;
    assign found_payload   = fpay_reg;
    assign entry_count     = cnt_out_reg;

endmodule
`default_nettype wire

// ----- src/skt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module skt_checker
    import skt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             done,
    input  wire logic             success,
    input  wire logic [POS_W-1:0] result_position,
    input  wire logic [PAY_W-1:0] found_payload,
    input  wire logic [CNT_W-1:0] entry_count
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request not followed by busy");

    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("busy not followed by a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !done)
        else $error("result without request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !success |-> result_position == '0 && found_payload == '0)
        else $error("failed result carries data");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .success         (success),
    .result_position (result_position),
    .found_payload   (found_payload),
    .entry_count     (entry_count)
);
`default_nettype wire
